// ----- sv/tsbs_pkg.sv -----
// Shared widths, register indexes and sequencer phase codes for the boxcar smoother.
package tsbs_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned GAIN_W   = 33;
  localparam int unsigned INT_W    = 56;
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned APB_AW   = 5;

  // Register index, taken from paddr[4:3] (registers sit 8 bytes apart)
  localparam logic [1:0] REG_FIRST_LEN  = 2'd0;
  localparam logic [1:0] REG_SECOND_LEN = 2'd1;
  localparam logic [1:0] REG_GAIN_RECIP = 2'd2;

  // Sequencer phases of one sample
  localparam logic [1:0] PH_TAP_A  = 2'd0;
  localparam logic [1:0] PH_TAP_B  = 2'd1;
  localparam logic [1:0] PH_TAP_AB = 2'd2;
  localparam logic [1:0] PH_SUM    = 2'd3;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 33'h1_0000_0000;

endpackage

// ----- sv/two_stage_boxcar_smoother.sv -----
// Top level of the two-stage boxcar smoother: comb on a RAM delay line, double integrator, scaling.
//
// Smooths a stream of signed Q8.24 samples with two cascaded moving averages of lengths
// A (first_length) and B (second_length). Each sample is written into a circular delay
// line held in one RAM; the comb x - d[-A] - d[-B] + d[-A-B] is followed by a 56-bit
// double integrator, and the result is scaled by gain_reciprocal (Q1.32, nominally
// 2^32/(A*B)), rounded toward minus infinity and saturated to 32 bits. A sample is taken
// when idle or in the last phase of the one before: the delay-line RAM has a single read
// port, so the three tap reads and the sample write occupy four sequencer phases. Each
// scaled result is queued; up to four results may wait for the downstream side
// before the input stalls. A length of 0 acts as 1. Writing either length register
// restarts the filter: the integrators and write pointer clear and a fill count makes
// every unwritten delay-line entry read as zero, so no clearing pass is needed and the
// block is ready at once after reset. Registers sit at byte addresses 0, 8 and 16 of a
// 64-bit APB port; write them only while no sample is in flight.
module two_stage_boxcar_smoother
  import tsbs_pkg::*;
#(
  parameter int unsigned ADDR_W = 12   // delay line holds 2**ADDR_W samples
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] sample_in
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [31:0] smoothed
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned DEPTH = 1 << ADDR_W;
  localparam int unsigned OFF_W = (ADDR_W > 12) ? ADDR_W : 12;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]  first_len_q, second_len_q;
  logic [GAIN_W-1:0] gain_q;
  logic              cfg_wr;
  logic              len_wr;
  logic [LEN_W-1:0]  wr_len;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign len_wr = cfg_wr && ((paddr[4:3] == REG_FIRST_LEN) || (paddr[4:3] == REG_SECOND_LEN));
  // a length of zero acts as one
  assign wr_len = (pwdata[LEN_W-1:0] == '0) ? LEN_RESET : pwdata[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= LEN_RESET;
      second_len_q <= LEN_RESET;
      gain_q       <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_FIRST_LEN:  first_len_q  <= wr_len;
        REG_SECOND_LEN: second_len_q <= wr_len;
        REG_GAIN_RECIP: gain_q       <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_FIRST_LEN:  prdata = APB_DW'(first_len_q);
      REG_SECOND_LEN: prdata = APB_DW'(second_len_q);
      REG_GAIN_RECIP: prdata = APB_DW'(gain_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: four phases per sample
  // ---------------------------------------------------------------------------
  logic              busy_q;
  logic [1:0]        ph_q;
  logic [2:0]        pending_q;    // samples accepted whose result has not left
  logic              in_beat, out_beat;
  logic [SAMPLE_W-1:0] x_q;

  // Hold the input once the output queue could not take every result in flight
  assign s_axis_tready = (!busy_q || (ph_q == PH_SUM)) && (pending_q < 3'd4);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_beat      = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      ph_q      <= PH_TAP_A;
      pending_q <= '0;
    end else begin
      if (in_beat) begin
        busy_q <= 1'b1;
        ph_q   <= PH_TAP_A;
      end else if (busy_q) begin
        if (ph_q == PH_SUM) begin
          busy_q <= 1'b0;
        end
        ph_q <= ph_q + 2'd1;
      end
      pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line: write pointer, fill count and tap addressing
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] wr_idx_q;
  logic [ADDR_W:0]   fill_q;       // samples held since restart, stops at DEPTH
  logic [OFF_W-1:0]  back_ext;
  logic [ADDR_W-1:0] back;
  logic [ADDR_W-1:0] rd_addr;
  logic              ram_we;
  logic [SAMPLE_W-1:0] rd_data;
  logic              tap_ok_q, tap_byp_q;
  logic              step_end;

  assign step_end = busy_q && (ph_q == PH_SUM);

  always_comb begin
    unique case (ph_q)
      PH_TAP_A:  back_ext = OFF_W'(first_len_q);
      PH_TAP_B:  back_ext = OFF_W'(second_len_q);
      default:   back_ext = OFF_W'({1'b0, first_len_q} + {1'b0, second_len_q});
    endcase
  end

  // tap offsets wrap around the line
  assign back    = back_ext[ADDR_W-1:0];
  assign rd_addr = wr_idx_q - back;
  assign ram_we  = busy_q && (ph_q == PH_TAP_A);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (len_wr) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (step_end) begin
      wr_idx_q <= wr_idx_q + ADDR_W'(1);
      if (fill_q != (ADDR_W+1)'(DEPTH)) begin
        fill_q <= fill_q + (ADDR_W+1)'(1);
      end
    end
  end

  // An entry never written since restart reads as zero; a zero offset is the sample itself.
  always_ff @(posedge clk_i) begin
    tap_ok_q  <= ({1'b0, back} <= fill_q);
    tap_byp_q <= (back == '0);
  end

  tsbs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (x_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Comb and double integrator
  // ---------------------------------------------------------------------------
  logic [INT_W-1:0]    acc_q, acc_d;
  logic [INT_W-1:0]    z1_q, z2_q;
  logic [SAMPLE_W-1:0] tap_raw;
  logic [INT_W-1:0]    tap_val, x_ext;

  assign tap_raw = tap_byp_q ? x_q : (tap_ok_q ? rd_data : '0);
  assign tap_val = {{(INT_W-SAMPLE_W){tap_raw[SAMPLE_W-1]}}, tap_raw};
  assign x_ext   = {{(INT_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};

  // Fold the integrator feedback in first, then take one tap per phase.
  always_comb begin
    unique case (ph_q)
      PH_TAP_A:  acc_d = x_ext + {z1_q[INT_W-2:0], 1'b0} - z2_q;
      PH_TAP_B:  acc_d = acc_q - tap_val;
      PH_TAP_AB: acc_d = acc_q - tap_val;
      default:   acc_d = acc_q + tap_val;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (len_wr) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (step_end) begin
      z2_q <= z1_q;
      z1_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Scaling: split multiply, sum, floor shift and saturation
  // ---------------------------------------------------------------------------
  logic               v1_q, v2_q, v3_q;
  logic [59:0]        p0_q;        // low 28 bits of sum times low 32 gain bits
  logic signed [60:0] p1_q;        // high 28 bits (signed) times low 32 gain bits
  logic [INT_W-1:0]   s2_q;
  logic               g_top_q;
  logic signed [60:0] p1_d;
  logic signed [89:0] prod;
  logic signed [57:0] q_q;
  logic [SAMPLE_W-1:0] sat;

  assign p1_d = $signed(z1_q[INT_W-1:28]) * $signed({1'b0, gain_q[31:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= step_end;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p0_q    <= z1_q[27:0] * gain_q[31:0];
      p1_q    <= p1_d;
      s2_q    <= z1_q;
      g_top_q <= gain_q[GAIN_W-1];
    end
    if (v2_q) begin
      q_q <= prod[89:32];
    end
  end

  assign prod = $signed({30'b0, p0_q})
              + ($signed({{29{p1_q[60]}}, p1_q}) <<< 28)
              + (g_top_q ? ($signed({{34{s2_q[INT_W-1]}}, s2_q}) <<< 32) : 90'sd0);

  // saturate to the signed 32-bit range
  always_comb begin
    if ((q_q[57:31] == '0) || (q_q[57:31] == '1)) begin
      sat = q_q[31:0];
    end else if (q_q[57]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  // ---------------------------------------------------------------------------
  // Four-entry output queue: results wait here while the downstream side stalls
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] fifo_q [4];
  logic [1:0]          wr_ptr_q, rd_ptr_q;
  logic [2:0]          cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (v3_q) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (out_beat) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(v3_q) - 3'(out_beat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      fifo_q[wr_ptr_q] <= sat;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

endmodule

// ----- sv/tsbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tsbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
